[hdl/mlwsum_pkg.sv]
`default_nettype none

package mlwsum_pkg;

    // Fixed field widths of the item and result channels.
    localparam int VALUE_W      = 16;
    localparam int TARGET_W     = 32;
    localparam int MIN_LEN_W    = 11;
    localparam int S_TDATA_W    = 16;
    localparam int M_TDATA_W    = 16;

    // Operation codes of the shared add/subtract unit.
    typedef logic alu_op_t;
    localparam alu_op_t ALU_ADD = 1'b0;
    localparam alu_op_t ALU_SUB = 1'b1;

endpackage : mlwsum_pkg

`default_nettype wire

[hdl/mlwsum_alu.sv]
`default_nettype none

// Shared adder/subtractor. For subtraction, carry_out high means a >= b.
module mlwsum_alu #(
    parameter int W = 32
) (
    input  wire mlwsum_pkg::alu_op_t op,
    input  wire logic [W-1:0]        a,
    input  wire logic [W-1:0]        b,
    output logic      [W-1:0]        result,
    output logic                     carry_out
);

    logic [W-1:0] b_eff;
    logic [W:0]   full_sum;

    // Subtraction is addition of the inverted operand with a carry in.
    always_comb begin
        b_eff    = (op == mlwsum_pkg::ALU_SUB) ? ~b : b;
        full_sum = {1'b0, a} + {1'b0, b_eff} + {{W{1'b0}}, op == mlwsum_pkg::ALU_SUB};
    end

    assign result    = full_sum[W-1:0];
    assign carry_out = full_sum[W];

endmodule : mlwsum_alu

`default_nettype wire

[hdl/mlwsum_store.sv]
`default_nettype none

// Window store: one write port and one registered read port.
module mlwsum_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic                               aclk,
    input  wire logic                               wr_en,
    input  wire logic [AW-1:0]                      wr_addr,
    input  wire logic [mlwsum_pkg::VALUE_W-1:0]     wr_data,
    input  wire logic [AW-1:0]                      rd_addr,
    output logic      [mlwsum_pkg::VALUE_W-1:0]     rd_data_reg
);

    logic [mlwsum_pkg::VALUE_W-1:0] mem [DEPTH];

    // Write the new back element.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read the front element every cycle.
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

endmodule : mlwsum_store

`default_nettype wire

[hdl/min_length_window_sum_at_least_core.sv]
// Shortest window whose sum reaches a target, over a sequence of values.
// Input channel s_*: one 16-bit unsigned value per item, s_tlast marks the
// final item of a sequence. Output channel m_*: one result per sequence,
// the shortest window length (0 if no window reached the target) in
// m_tdata and the overflow flag in m_tuser.
// Configuration channel cfg_*: writes the 32-bit target sum (reset value 1).
// Each item is written to the window store and added to the sum in the
// idle state, then compared with the target in the check state; every
// element removed from the front of the window passes through the shrink
// state and a further compare, and is removed at most once. The single
// shared add/subtract unit and the one read port of the window store
// serialise these steps. After the last compare the finish state registers
// the result into the output register once it is free. Items beyond
// MAX_ITEMS in one sequence are dropped and raise the overflow flag.
// Reset clears the sequence state, the output valid and sets the target to
// 1. If the receiver stalls, the result is held in the output register and
// items of the next sequence are still taken; only after a further last
// item does the sequencer wait until the held result has been taken.
`default_nettype none

module min_length_window_sum_at_least_core #(
    parameter int MAX_ITEMS = 1024
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // Input items
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [mlwsum_pkg::S_TDATA_W-1:0]   s_tdata,  // [15:0] value
    input  wire logic                               s_tlast,
    // Results
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic      [mlwsum_pkg::M_TDATA_W-1:0]   m_tdata,  // [10:0] min_length, [15:11] zero
    output logic                                    m_tuser,  // [0] overflow
    // Target register
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [mlwsum_pkg::TARGET_W-1:0]    cfg_data
);

    localparam int AW     = (MAX_ITEMS > 2) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int SUM_W  = mlwsum_pkg::VALUE_W + CNT_W;
    localparam int CMP_W  = (SUM_W > mlwsum_pkg::TARGET_W) ? SUM_W : mlwsum_pkg::TARGET_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_CHECK  = 2'd1;
    localparam logic [1:0] ST_SHRINK = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]                          state_reg, state_next;
    logic [CNT_W-1:0]                    front_reg, front_next;
    logic [CNT_W-1:0]                    back_reg, back_next;
    logic [SUM_W-1:0]                    sum_reg, sum_next;
    logic [CNT_W-1:0]                    best_reg, best_next;
    logic                                ovf_reg, ovf_next;
    logic                                last_reg, last_next;
    logic [mlwsum_pkg::TARGET_W-1:0]     target_reg;
    logic                                m_valid_reg, m_valid_next;
    logic [mlwsum_pkg::MIN_LEN_W-1:0]    m_len_reg, m_len_next;
    logic                                m_ovf_reg, m_ovf_next;

    mlwsum_pkg::alu_op_t                 alu_op;
    logic [CMP_W-1:0]                    alu_a, alu_b, alu_result;
    logic                                alu_carry;

    logic                                s_accept;
    logic                                has_room;
    logic                                out_free;
    logic [CNT_W-1:0]                    win_len;
    logic [mlwsum_pkg::VALUE_W-1:0]      rd_data;
    logic                                wr_en;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign has_room  = (back_reg < CNT_W'(MAX_ITEMS));
    assign out_free  = !m_valid_reg || m_tready;
    assign win_len   = back_reg - front_reg;
    assign wr_en     = s_accept && has_room;
    assign cfg_ready = 1'b1;

    // Window store.
    mlwsum_store #(
        .DEPTH (MAX_ITEMS),
        .AW    (AW)
    ) u_store (
        .aclk        (aclk),
        .wr_en       (wr_en),
        .wr_addr     (back_reg[AW-1:0]),
        .wr_data     (s_tdata[mlwsum_pkg::VALUE_W-1:0]),
        .rd_addr     (front_reg[AW-1:0]),
        .rd_data_reg (rd_data)
    );

    // Operand selection for the shared unit.
    always_comb begin
        alu_a = CMP_W'(sum_reg);
        unique case (state_reg)
            ST_IDLE: begin
                alu_op = mlwsum_pkg::ALU_ADD;
                alu_b  = CMP_W'(s_tdata[mlwsum_pkg::VALUE_W-1:0]);
            end
            ST_CHECK: begin
                alu_op = mlwsum_pkg::ALU_SUB;
                alu_b  = CMP_W'(target_reg);
            end
            ST_SHRINK: begin
                alu_op = mlwsum_pkg::ALU_SUB;
                alu_b  = CMP_W'(rd_data);
            end
            default: begin
                alu_op = mlwsum_pkg::ALU_ADD;
                alu_b  = '0;
            end
        endcase
    end

    mlwsum_alu #(
        .W (CMP_W)
    ) u_alu (
        .op        (alu_op),
        .a         (alu_a),
        .b         (alu_b),
        .result    (alu_result),
        .carry_out (alu_carry)
    );

    // Sequencer.
    always_comb begin
        state_next   = state_reg;
        front_next   = front_reg;
        back_next    = back_reg;
        sum_next     = sum_reg;
        best_next    = best_reg;
        ovf_next     = ovf_reg;
        last_next    = last_reg;
        m_valid_next = m_valid_reg;
        m_len_next   = m_len_reg;
        m_ovf_next   = m_ovf_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    last_next = s_tlast;
                    if (has_room) begin
                        back_next  = back_reg + CNT_W'(1);
                        sum_next   = alu_result[SUM_W-1:0];
                        state_next = ST_CHECK;
                    end else begin
                        ovf_next = 1'b1;
                        if (s_tlast) begin
                            state_next = ST_FINISH;
                        end
                    end
                end
            end
            ST_CHECK: begin
                // The window qualifies while it is not empty and sum >= target.
                if ((front_reg < back_reg) && alu_carry) begin
                    if ((best_reg == '0) || (win_len < best_reg)) begin
                        best_next = win_len;
                    end
                    state_next = ST_SHRINK;
                end else if (last_reg) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_SHRINK: begin
                sum_next   = alu_result[SUM_W-1:0];
                front_next = front_reg + CNT_W'(1);
                state_next = ST_CHECK;
            end
            ST_FINISH: begin
                // Hand the result over once the output register is free.
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_len_next   = mlwsum_pkg::MIN_LEN_W'(best_reg);
                    m_ovf_next   = ovf_reg;
                    front_next   = '0;
                    back_next    = '0;
                    sum_next     = '0;
                    best_next    = '0;
                    ovf_next     = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and sequence state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            front_reg   <= '0;
            back_reg    <= '0;
            sum_reg     <= '0;
            best_reg    <= '0;
            ovf_reg     <= 1'b0;
            last_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            target_reg  <= mlwsum_pkg::TARGET_W'(1);
        end else begin
            state_reg   <= state_next;
            front_reg   <= front_next;
            back_reg    <= back_next;
            sum_reg     <= sum_next;
            best_reg    <= best_next;
            ovf_reg     <= ovf_next;
            last_reg    <= last_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                target_reg <= cfg_data;
            end
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        m_len_reg <= m_len_next;
        m_ovf_reg <= m_ovf_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = mlwsum_pkg::M_TDATA_W'(m_len_reg);
    assign m_tuser  = m_ovf_reg;

    // The front of the window never passes the back.
    assert property (@(posedge aclk) disable iff (!aresetn)
        front_reg <= back_reg)
        else $error("front pointer beyond back pointer");

    // An empty window between items holds a sum of zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && front_reg == back_reg) |-> sum_reg == '0)
        else $error("empty window with non-zero sum");

    // The best length never exceeds the number of stored items.
    assert property (@(posedge aclk) disable iff (!aresetn)
        best_reg <= back_reg)
        else $error("best length larger than sequence");

    // Handing over a result clears the sequence and raises valid.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && out_free)
            |=> (back_reg == '0 && best_reg == '0 && m_valid_reg))
        else $error("sequence not cleared after result");

endmodule : min_length_window_sum_at_least_core

`default_nettype wire
